### sv/jsu_pkg.sv
// Shared types, constants and decode functions for the JSON string unescaper.
package jsu_pkg;

	// Record queue between decode and output stages
	localparam int MAX_BYTES = 3;
	localparam int NB_W      = 2;
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = 2;

	// Byte codes the scanner reacts to
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;

	// UTF-8 encoding constants
	localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
	localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
	localparam logic [7:0]  UTF_CONT     = 8'h80;
	localparam logic [7:0]  UTF_LEAD2    = 8'hC0;
	localparam logic [7:0]  UTF_LEAD3    = 8'hE0;

	typedef struct packed {
		logic [7:0] ch;
		logic       buffer_end;
	} item_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       has_byte;
		logic       string_end;
		logic       last;
	} result_t;

	// Work for the output stage: decoded bytes of one input byte
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [NB_W-1:0]           nb;
		logic                      ended;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] value;
	} esc_t;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_ESCAPE = 3'b010,
		MODE_HEX    = 3'b100
	} mode_t;

	function automatic hex_t hex_digit(input logic [7:0] c);
		hex_t r;
		r.ok  = 1'b1;
		r.val = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r.val = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r.val = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r.val = 4'(c - 8'h37);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic esc_t esc_map(input logic [7:0] c);
		esc_t r;
		r.ok    = 1'b1;
		r.value = c;
		priority case (c)
			CH_LOW_N:  r.value = CH_LF;
			CH_LOW_T:  r.value = CH_TAB;
			CH_LOW_R:  r.value = CH_CR;
			CH_QUOTE:  r.value = CH_QUOTE;
			CH_BSLASH: r.value = CH_BSLASH;
			CH_SLASH:  r.value = CH_SLASH;
			default:   r.ok = 1'b0;
		endcase
		return r;
	endfunction

endpackage

### sv/jsu_front.sv
// Scanner stage: accepts raw string bytes and turns them into records of decoded bytes.
module jsu_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  jsu_pkg::item_t  item,
	output logic            item_stall,
	input  jsu_pkg::q_stat_t q_stat,
	output logic            rec_push,
	output jsu_pkg::rec_t   rec
);

	jsu_pkg::mode_t mode_q, mode_d;
	logic [1:0]     cnt_q, cnt_d;
	logic [15:0]    acc_q, acc_d;
	logic           halt_q, halt_d;
	logic [7:0]     pend_q [3];
	logic           pend_we;
	logic           accept;

	assign item_stall = q_stat.full;
	assign accept     = item_valid && !q_stat.full;
	assign rec_push   = accept && (rec.nb != '0 || rec.ended);

	// Decode the current byte against the scan state
	always_comb begin
		jsu_pkg::hex_t hx;
		jsu_pkg::esc_t es;
		jsu_pkg::esc_t rm;
		logic [15:0]   acc_f;
		logic          halt_f;
		logic [7:0]    seq [3];
		logic [1:0]    rn;
		logic          esc_f;
		logic          stop;
		mode_d  = mode_q;
		cnt_d   = cnt_q;
		acc_d   = acc_q;
		halt_d  = halt_q;
		pend_we = 1'b0;
		rec     = '0;
		hx      = jsu_pkg::hex_digit(item.ch);
		es      = jsu_pkg::esc_map(item.ch);
		halt_f  = halt_q || !hx.ok;
		acc_f   = halt_f ? acc_q : {acc_q[11:0], hx.val};
		rn      = 2'd0;
		esc_f   = 1'b0;
		stop    = 1'b0;
		rm      = '0;
		for (int i = 0; i < 3; i++) begin
			seq[i] = (2'(i) < cnt_q) ? pend_q[i] : item.ch;
		end
		unique case (mode_q)
			jsu_pkg::MODE_ESCAPE: begin
				mode_d = jsu_pkg::MODE_NORMAL;
				if (es.ok) begin
					rec.bytes[0] = es.value;
					rec.nb       = 2'd1;
				end else if (item.ch == jsu_pkg::CH_LOW_U && !item.buffer_end) begin
					mode_d = jsu_pkg::MODE_HEX;
					cnt_d  = 2'd0;
					acc_d  = 16'd0;
					halt_d = 1'b0;
				end
				rec.ended = item.buffer_end;
			end
			jsu_pkg::MODE_HEX: begin
				if (cnt_q == 2'd3) begin
					// Fourth character: fold and encode the code unit
					acc_d  = acc_f;
					halt_d = halt_f;
					mode_d = jsu_pkg::MODE_NORMAL;
					if (acc_f < jsu_pkg::CP_ONE_LIMIT) begin
						rec.bytes[0] = acc_f[7:0];
						rec.nb       = 2'd1;
					end else if (acc_f < jsu_pkg::CP_TWO_LIMIT) begin
						rec.bytes[0] = jsu_pkg::UTF_LEAD2 | {3'd0, acc_f[10:6]};
						rec.bytes[1] = jsu_pkg::UTF_CONT | {2'd0, acc_f[5:0]};
						rec.nb       = 2'd2;
					end else begin
						rec.bytes[0] = jsu_pkg::UTF_LEAD3 | {4'd0, acc_f[15:12]};
						rec.bytes[1] = jsu_pkg::UTF_CONT | {2'd0, acc_f[11:6]};
						rec.bytes[2] = jsu_pkg::UTF_CONT | {2'd0, acc_f[5:0]};
						rec.nb       = 2'd3;
					end
					rec.ended = item.buffer_end;
				end else if (item.buffer_end) begin
					// Buffer ends inside the escape: replay collected characters
					for (int i = 0; i < 3; i++) begin
						if (2'(i) <= cnt_q && !stop) begin
							if (esc_f) begin
								esc_f = 1'b0;
								rm    = jsu_pkg::esc_map(seq[i]);
								if (rm.ok) begin
									rec.bytes[rn] = rm.value;
									rn            = rn + 2'd1;
								end
							end else if (seq[i] == jsu_pkg::CH_QUOTE) begin
								stop = 1'b1;
							end else if (seq[i] == jsu_pkg::CH_BSLASH) begin
								esc_f = 1'b1;
							end else begin
								rec.bytes[rn] = seq[i];
								rn            = rn + 2'd1;
							end
						end
					end
					rec.nb    = rn;
					mode_d    = jsu_pkg::MODE_NORMAL;
					rec.ended = 1'b1;
				end else begin
					acc_d   = acc_f;
					halt_d  = halt_f;
					pend_we = 1'b1;
					cnt_d   = cnt_q + 2'd1;
				end
			end
			default: begin
				mode_d = jsu_pkg::MODE_NORMAL;
				if (item.ch == jsu_pkg::CH_QUOTE) begin
					rec.ended = 1'b1;
				end else if (item.ch == jsu_pkg::CH_BSLASH) begin
					if (item.buffer_end) begin
						rec.ended = 1'b1;
					end else begin
						mode_d = jsu_pkg::MODE_ESCAPE;
					end
				end else begin
					rec.bytes[0] = item.ch;
					rec.nb       = 2'd1;
					rec.ended    = item.buffer_end;
				end
			end
		endcase
	end

	// Advance scan state on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::MODE_NORMAL;
			cnt_q  <= 2'd0;
			acc_q  <= 16'd0;
			halt_q <= 1'b0;
		end else if (accept) begin
			mode_q <= mode_d;
			cnt_q  <= cnt_d;
			acc_q  <= acc_d;
			halt_q <= halt_d;
		end
	end

	// Hold characters collected after \u for a possible replay
	always_ff @(posedge clk) begin
		if (accept && pend_we) begin
			pend_q[cnt_q] <= item.ch;
		end
	end

endmodule

### sv/jsu_queue.sv
// Small record queue between the scanner and the output stage.
module jsu_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  jsu_pkg::rec_t    push_rec,
	input  logic             pop,
	output jsu_pkg::rec_t    head,
	output jsu_pkg::q_stat_t q_stat
);

	jsu_pkg::rec_t                mem_q [jsu_pkg::QDEPTH];
	logic [jsu_pkg::QPTR_W-1:0]   wr_q;
	logic [jsu_pkg::QPTR_W-1:0]   rd_q;
	logic [jsu_pkg::QPTR_W:0]     cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign q_stat.full  = (cnt_q == (jsu_pkg::QPTR_W + 1)'(jsu_pkg::QDEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_push      = push && !q_stat.full;
	assign do_pop       = pop && !q_stat.empty;
	assign head         = mem_q[rd_q];

	// Store records
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_rec;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### sv/jsu_back.sv
// Output stage: walks each record and sends one result per transfer.
module jsu_back (
	input  logic             clk,
	input  logic             arst_n,
	input  jsu_pkg::q_stat_t q_stat,
	input  jsu_pkg::rec_t    head,
	output logic             pop,
	output logic             result_valid,
	output jsu_pkg::result_t result,
	input  logic             result_stall
);

	logic [jsu_pkg::NB_W-1:0] idx_q;
	logic                     val_q;
	jsu_pkg::result_t         res_q;
	jsu_pkg::result_t         cur;
	logic                     load;
	logic                     take;
	logic                     is_last;

	assign load         = !val_q || !result_stall;
	assign take         = load && !q_stat.empty;
	assign is_last      = (head.nb == '0) ||
	                      (idx_q == jsu_pkg::NB_W'(head.nb - 2'd1));
	assign pop          = take && is_last;
	assign result_valid = val_q;
	assign result       = res_q;

	// Build the result for the current byte of the head record
	always_comb begin
		cur.has_byte   = (head.nb != '0);
		cur.byte_value = cur.has_byte ? head.bytes[idx_q] : 8'd0;
		cur.string_end = head.ended && is_last;
		cur.last       = is_last;
	end

	// Output register and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) begin
				val_q <= !q_stat.empty;
			end
			if (take) begin
				idx_q <= is_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= cur;
		end
	end

endmodule

### sv/json_string_unescape_utf8.sv
// JSON string unescaper top level: scanner, record queue and output stage.
// Feed the body bytes of a JSON string, one per transfer, starting after the opening quote;
// results carry the unescaped bytes, with \uXXXX expanded to 1 to 3 UTF-8 bytes. An input
// byte is taken every cycle while the four-entry record queue has room; the output stage
// sends one result per cycle while result_stall is low, so a byte that decodes to N bytes
// yields N results (a single result when it only ends the string, none when it yields
// nothing). Each record passes through the queue and then the output register.
module json_string_unescape_utf8 (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  jsu_pkg::item_t   item,
	output logic             item_stall,
	output logic             result_valid,
	output jsu_pkg::result_t result,
	input  logic             result_stall
);

	jsu_pkg::q_stat_t q_stat;
	jsu_pkg::rec_t    rec;
	jsu_pkg::rec_t    head;
	logic             rec_push;
	logic             rec_pop;

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_stall (item_stall),
		.q_stat     (q_stat),
		.rec_push   (rec_push),
		.rec        (rec)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (rec_push),
		.push_rec (rec),
		.pop      (rec_pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head         (head),
		.pop          (rec_pop),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		rec_push |-> !q_stat.full)
		else $error("record pushed into full queue");

	a_empty_result_ends: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.has_byte |-> result.string_end && result.last)
		else $error("byteless result does not end the string");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.string_end |-> result.last)
		else $error("string end not on final result of its byte");
`endif

endmodule
